@@ sv/ftdt_pkg.sv @@
// shared types and constants for the frame timing deadline tracker
package ftdt_pkg;

   localparam int HistDepth = 64;
   localparam int IdxW      = $clog2(HistDepth);
   localparam int CntW      = IdxW + 1;
   localparam int TimeW     = 48;
   localparam int IdW       = 32;
   localparam int QuoW      = 20;
   localparam int StepW     = 6;
   localparam int CsrIdxW   = 2;
   localparam int CsrDataW  = 10;

   localparam logic [TimeW-1:0] Period60  = TimeW'(16666);
   localparam logic [TimeW-1:0] Period144 = TimeW'(6944);
   localparam logic [QuoW-1:0]  UsPerSec  = QuoW'(1000000);

   localparam logic [StepW-1:0] DivSteps = StepW'(QuoW);
   localparam logic [StepW-1:0] ModSteps = StepW'(TimeW);

   localparam logic [1:0] KindSubmit  = 2'd0;
   localparam logic [1:0] KindPresent = 2'd1;
   localparam logic [1:0] KindQuery   = 2'd2;

   localparam logic [2:0] ModeImmediate = 3'd0;
   localparam logic [2:0] ModeFixed60   = 3'd1;
   localparam logic [2:0] ModeFixed144  = 3'd2;
   localparam logic [2:0] ModeAdaptive  = 3'd3;
   localparam logic [2:0] ModeVsync     = 3'd4;

   localparam logic [CsrIdxW-1:0] CsrActive = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrMode   = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrRate   = 2'd2;

   typedef struct packed {
      logic [1:0]       kind;
      logic [IdW-1:0]   frame_tag;
      logic [TimeW-1:0] event_time;
      logic [TimeW-1:0] vbi_time;
   } req_type;

   typedef struct packed {
      logic             status;
      logic             latency_valid;
      logic [TimeW-1:0] latency;
      logic [TimeW-1:0] deadline;
   } rsp_type;

   typedef struct packed {
      logic cap;
      logic wr;
      logic srch_start;
      logic srch_step;
      logic div_start;
      logic div_step;
      logic mod_start;
      logic mod_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       need_div;
      logic       need_mod;
      logic       srch_done;
   } sts_type;

endpackage

@@ sv/ftdt_dp.sv @@
// datapath: frame history memory, search compare, shared divider, result register
module ftdt_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  ftdt_pkg::cmd_type        cmd,
   output ftdt_pkg::sts_type        sts,
   input  ftdt_pkg::req_type        req_data,
   output ftdt_pkg::rsp_type        rsp_data,
   input  logic                     csr_write,
   input  logic [ftdt_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [ftdt_pkg::CsrDataW-1:0] csr_data
);
   import ftdt_pkg::*;

   logic [IdW+TimeW-1:0] mem [HistDepth];

   req_type              req_ff;
   logic                 active_ff;
   logic [2:0]           mode_ff;
   logic [9:0]           rate_ff;
   logic [IdxW-1:0]      wp_ff;
   logic [CntW-1:0]      vcnt_ff;
   logic [CntW-1:0]      idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic [IdW+TimeW-1:0] rd_ff;
   logic                 match_ff;
   logic [TimeW-1:0]     mt_ff;
   logic [TimeW-1:0]     num_ff;
   logic [QuoW-1:0]      rem_ff;
   logic [QuoW-1:0]      den_ff;
   rsp_type              rsp_ff, rsp_in;

   logic                 hit;
   logic [IdxW-1:0]      rd_addr;
   logic [QuoW:0]        trial;
   logic                 q_bit;
   logic [TimeW-1:0]     elapsed;
   logic                 vsync_ok;

   assign hit      = pend_ff && (rd_ff[IdW+TimeW-1:TimeW] == req_ff.frame_tag);
   assign rd_addr  = wp_ff - idx_ff[IdxW-1:0] - IdxW'(1);
   assign trial    = {rem_ff, num_ff[TimeW-1]};
   assign q_bit    = trial >= {1'b0, den_ff};
   assign elapsed  = req_ff.event_time - req_ff.vbi_time;
   assign vsync_ok = (rate_ff != '0) && (req_ff.vbi_time != '0);

   assign sts.kind      = req_ff.kind;
   assign sts.need_div  = active_ff && (rate_ff != '0) &&
                          ((mode_ff == ModeAdaptive) || (mode_ff == ModeVsync && vsync_ok));
   assign sts.need_mod  = (mode_ff == ModeVsync);
   assign sts.srch_done = hit || (!pend_ff && (idx_ff == vcnt_ff));
   assign rsp_data      = rsp_ff;

   always_comb begin
      idx_in  = idx_ff;
      pend_in = 1'b0;
      if (cmd.srch_start) begin
         idx_in = '0;
      end else if (cmd.srch_step && !hit && idx_ff != vcnt_ff) begin
         idx_in  = idx_ff + CntW'(1);
         pend_in = 1'b1;
      end
   end

   always_comb begin
      rsp_in = '0;
      case (req_ff.kind)
         KindPresent: begin
            rsp_in.status = !match_ff;
            if (match_ff && mt_ff != '0 && req_ff.event_time >= mt_ff) begin
               rsp_in.latency_valid = 1'b1;
               rsp_in.latency       = req_ff.event_time - mt_ff;
            end
         end
         KindQuery: begin
            if (!active_ff) begin
               rsp_in.deadline = req_ff.event_time + Period60;
            end else begin
               case (mode_ff)
                  ModeImmediate: rsp_in.deadline = req_ff.event_time;
                  ModeFixed144:  rsp_in.deadline = req_ff.event_time + Period144;
                  ModeAdaptive: begin
                     if (rate_ff != '0) begin
                        rsp_in.deadline = req_ff.event_time + TimeW'(num_ff[QuoW-1:0]);
                     end else begin
                        rsp_in.deadline = req_ff.event_time + Period60;
                     end
                  end
                  ModeVsync: begin
                     if (vsync_ok) begin
                        rsp_in.deadline = req_ff.event_time + TimeW'(den_ff - rem_ff);
                     end else begin
                        rsp_in.deadline = req_ff.event_time + Period60;
                     end
                  end
                  default: rsp_in.deadline = req_ff.event_time + Period60;
               endcase
            end
         end
         default: rsp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mem[wp_ff] <= {req_ff.frame_tag, req_ff.event_time};
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         mode_ff   <= ModeFixed60;
         rate_ff   <= 10'd60;
         wp_ff     <= '0;
         vcnt_ff   <= '0;
         idx_ff    <= '0;
         pend_ff   <= 1'b0;
         match_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CsrActive: active_ff <= csr_data[0];
               CsrMode:   mode_ff   <= csr_data[2:0];
               CsrRate:   rate_ff   <= csr_data;
               default:   ;
            endcase
         end
         if (cmd.wr) begin
            wp_ff <= wp_ff + IdxW'(1);
            if (vcnt_ff != CntW'(HistDepth)) begin
               vcnt_ff <= vcnt_ff + CntW'(1);
            end
         end
         idx_ff  <= idx_in;
         pend_ff <= pend_in;
         if (cmd.srch_start) begin
            match_ff <= 1'b0;
         end else if (cmd.srch_step && hit) begin
            match_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         req_ff <= req_data;
      end
      if (cmd.srch_step && hit) begin
         mt_ff <= rd_ff[TimeW-1:0];
      end
      if (cmd.div_start) begin
         num_ff <= {UsPerSec, (TimeW-QuoW)'(0)};
         rem_ff <= '0;
         den_ff <= QuoW'(rate_ff);
      end else if (cmd.mod_start) begin
         num_ff <= elapsed;
         rem_ff <= '0;
         den_ff <= num_ff[QuoW-1:0];
      end else if (cmd.div_step || cmd.mod_step) begin
         rem_ff <= q_bit ? QuoW'(trial - {1'b0, den_ff}) : trial[QuoW-1:0];
         num_ff <= {num_ff[TimeW-2:0], q_bit};
      end
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

@@ sv/ftdt_ctrl.sv @@
// controller: sequences one item through search, divide and result transfer
module ftdt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  ftdt_pkg::sts_type   sts,
   output ftdt_pkg::cmd_type   cmd
);
   import ftdt_pkg::*;

   typedef enum logic [2:0] {
      IDLE, DISP, SRCH, DIV, MODL, MOD, FIN
   } state_type;

   state_type        state_ff, state_in;
   logic [StepW-1:0] cnt_ff, cnt_in;
   logic             rv_ff, rv_in;
   logic             out_free;

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rv_ff;
   assign out_free  = !rv_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      rv_in    = rv_ff && rsp_stall;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.cap  = 1'b1;
               state_in = DISP;
            end
         end
         DISP: begin
            cnt_in = '0;
            case (sts.kind)
               KindSubmit: begin
                  cmd.wr   = 1'b1;
                  state_in = FIN;
               end
               KindPresent: begin
                  cmd.srch_start = 1'b1;
                  state_in       = SRCH;
               end
               KindQuery: begin
                  if (sts.need_div) begin
                     cmd.div_start = 1'b1;
                     state_in      = DIV;
                  end else begin
                     state_in = FIN;
                  end
               end
               default: state_in = FIN;
            endcase
         end
         SRCH: begin
            cmd.srch_step = 1'b1;
            if (sts.srch_done) begin
               state_in = FIN;
            end
         end
         DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + StepW'(1);
            if (cnt_ff == DivSteps - StepW'(1)) begin
               state_in = sts.need_mod ? MODL : FIN;
            end
         end
         MODL: begin
            cmd.mod_start = 1'b1;
            cnt_in        = '0;
            state_in      = MOD;
         end
         MOD: begin
            cmd.mod_step = 1'b1;
            cnt_in       = cnt_ff + StepW'(1);
            if (cnt_ff == ModSteps - StepW'(1)) begin
               state_in = FIN;
            end
         end
         FIN: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rv_in        = 1'b1;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
      end
   end

endmodule

@@ sv/frame_timing_deadline_tracker.sv @@
// Frame timing deadline tracker for one display.
// Request channel (req_valid, req_stall, req_data) carries submit, present and
// deadline query items; each item gives one transfer on the response channel
// (rsp_valid, rsp_stall, rsp_data). The csr_ port writes display_active (0),
// pacing mode (1) and refresh rate in Hz (2); the user writes them only while
// the block is idle, which it does not check. One item at a time: req_stall
// is high from the transfer until the result loads into the output register.
// Work per item after the request transfer:
//   submit: one history write; reserved kinds: no work
//   present: reads the history newest first until a match is found or every
//   held entry is read; one memory read per entry
//   deadline query: direct, or through the bit-serial divider with adaptive
//   sync (20 quotient steps) or vsync alignment (plus 48 remainder steps)
// A waiting result stays in the output register while the next item is
// accepted; a new result loads only once the old one is taken, so a stalled
// receiver holds the block in its final step.
// Reset zeroes the history count, write pointer and display_active, sets mode
// to 1 and rate to 60; no clearing pass: only written entries are searched.
module frame_timing_deadline_tracker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  ftdt_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output ftdt_pkg::rsp_type             rsp_data,
   input  logic                          csr_write,
   input  logic [ftdt_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [ftdt_pkg::CsrDataW-1:0] csr_data
);
   import ftdt_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ftdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ftdt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule

@@ sv/ftdt_checker.sv @@
// port-level checks for the frame timing deadline tracker and their bind
module ftdt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ftdt_pkg::rsp_type rsp_data
);

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request transfer did not close the request channel");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared without an item in progress");

   a_fields_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.deadline != '0 |-> !rsp_data.latency_valid && !rsp_data.status)
      else $error("deadline result carries present fields");

endmodule

bind frame_timing_deadline_tracker ftdt_checker u_ftdt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

@@ test/tb_frame_timing_deadline_tracker.sv @@
// testbench for the frame timing deadline tracker checked against a predictor
module tb_frame_timing_deadline_tracker;
   import ftdt_pkg::*;

   localparam int WatchLimit = 20000;
   localparam logic [1:0] KindReserved = 2'd3;
   localparam logic [CsrIdxW-1:0] CsrNone = 2'd3;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_write;
   logic [CsrIdxW-1:0] csr_index;
   logic [CsrDataW-1:0] csr_data;

   frame_timing_deadline_tracker dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // predictor state
   logic             active_m;
   logic [2:0]       mode_m;
   logic [9:0]       rate_m;
   logic [IdW-1:0]   hist_id [HistDepth];
   logic [TimeW-1:0] hist_time [HistDepth];
   int               wr_ptr;
   int               filled;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int  errors;
   int  idle_calm;
   int  watch;
   logic hold_req;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [TimeW-1:0] deadline_of(logic [TimeW-1:0] now,
                                                    logic [TimeW-1:0] vbi);
      logic [TimeW-1:0] per;
      logic [TimeW-1:0] ivl;
      logic [TimeW-1:0] rem;
      per = Period60;
      if (!active_m) return now + Period60;
      case (mode_m)
         ModeImmediate: return now;
         ModeFixed144: per = Period144;
         ModeAdaptive: if (rate_m != 0) per = 1000000 / rate_m;
         ModeVsync: if (rate_m != 0 && vbi != 0) begin
            ivl = 1000000 / rate_m;
            rem = (now - vbi) % ivl;
            return now + (ivl - rem);
         end
         default: ;
      endcase
      return now + per;
   endfunction

   function automatic rsp_type track_item(req_type r);
      rsp_type o;
      int idx;
      o = '0;
      if (r.kind == KindSubmit) begin
         hist_id[wr_ptr] = r.frame_tag;
         hist_time[wr_ptr] = r.event_time;
         wr_ptr = (wr_ptr + 1) % HistDepth;
         if (filled < HistDepth) filled++;
      end else if (r.kind == KindPresent) begin
         o.status = 1'b1;
         for (int i = 0; i < filled; i++) begin
            idx = (wr_ptr + HistDepth - 1 - i) % HistDepth;
            if (hist_id[idx] == r.frame_tag) begin
               o.status = 1'b0;
               if (hist_time[idx] != 0 && r.event_time >= hist_time[idx]) begin
                  o.latency_valid = 1'b1;
                  o.latency = r.event_time - hist_time[idx];
               end
               break;
            end
         end
      end else if (r.kind == KindQuery) begin
         o.deadline = deadline_of(r.event_time, r.vbi_time);
      end
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_reqs.size() != 0 && !hold_req
               && (idle_calm > 0 || $urandom_range(99) >= 9)) begin
            req_valid <= 1'b1;
            req_data <= pending_reqs.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
      if (!reset) rsp_stall <= (idle_calm == 0) && ($urandom_range(99) < 9);
      if (idle_calm > 0) idle_calm <= idle_calm - 1;
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            watch <= 0;
         end else begin
            watch <= watch + 1;
         end
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(track_item(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected transfer %h", rsp_data);
               errors++;
            end else begin
               rsp_type e;
               e = expected_rsps.pop_front();
               if (e.status !== rsp_data.status) begin
                  $error("status exp %h got %h", e.status, rsp_data.status); errors++;
               end
               if (e.latency_valid !== rsp_data.latency_valid) begin
                  $error("latency_valid exp %h got %h", e.latency_valid,
                         rsp_data.latency_valid); errors++;
               end
               if (e.latency !== rsp_data.latency) begin
                  $error("latency exp %h got %h", e.latency, rsp_data.latency); errors++;
               end
               if (e.deadline !== rsp_data.deadline) begin
                  $error("deadline exp %h got %h", e.deadline, rsp_data.deadline); errors++;
               end
            end
         end
         if (watch >= WatchLimit) begin
            $display("FAIL frame_timing_deadline_tracker");
            $finish;
         end
      end
   end

   task automatic drain();
      wait (pending_reqs.size() == 0);
      @(posedge clock);
      while (req_valid || expected_rsps.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CsrActive) active_m = val[0];
      else if (idx == CsrMode) mode_m = val[2:0];
      else if (idx == CsrRate) rate_m = val;
   endtask

   function automatic req_type make_req(logic [1:0] k, logic [IdW-1:0] id,
                                        logic [TimeW-1:0] t, logic [TimeW-1:0] v);
      req_type r;
      r.kind = k; r.frame_tag = id; r.event_time = t; r.vbi_time = v;
      return r;
   endfunction

   function automatic logic [TimeW-1:0] rand_time();
      case ($urandom_range(3))
         0: return TimeW'($urandom_range(40000));
         1: return TimeW'({$urandom, $urandom});
         2: return {TimeW{1'b1}} - $urandom_range(40000);
         default: return {16'($urandom), 32'($urandom)};
      endcase
   endfunction

   task automatic random_phase(int n);
      logic [IdW-1:0] ids [8];
      logic [TimeW-1:0] base;
      logic [1:0] k;
      for (int i = 0; i < 8; i++) ids[i] = $urandom;
      base = rand_time();
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(9) < 4 ? KindSubmit : ($urandom_range(9) < 6 ? KindPresent
             : ($urandom_range(19) == 0 ? KindReserved : KindQuery));
         base = base + $urandom_range(3000);
         if ($urandom_range(9) == 0)
            pending_reqs.push_back(make_req(k, $urandom, rand_time(), rand_time()));
         else
            pending_reqs.push_back(make_req(k, ids[$urandom_range(7)],
               $urandom_range(9) == 0 ? base - $urandom_range(5000) : base,
               $urandom_range(7) == 0 ? '0 : base - $urandom_range(30000)));
      end
   endtask

   initial begin
      logic [CsrDataW-1:0] rates [6];
      errors = 0; watch = 0; idle_calm = 0; hold_req = 0;
      wr_ptr = 0; filled = 0;
      active_m = 0; mode_m = ModeFixed60; rate_m = 60;
      reset = 1; req_valid = 0; req_data = '0; rsp_stall = 0;
      csr_write = 0; csr_index = '0; csr_data = '0;
      rates = '{10'd60, 10'd1, 10'd1000, 10'd0, 10'd144, 10'd1023};
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset settings, history edges, special cases
      pending_reqs.push_back(make_req(KindQuery, '0, '1, '1));
      pending_reqs.push_back(make_req(KindPresent, 32'h1, 48'd5, '0));
      pending_reqs.push_back(make_req(KindSubmit, '1, '0, '1));
      pending_reqs.push_back(make_req(KindPresent, '1, 48'd10, '0));
      pending_reqs.push_back(make_req(KindSubmit, 32'h7, 48'd500, '0));
      pending_reqs.push_back(make_req(KindSubmit, 32'h7, 48'd900, '0));
      pending_reqs.push_back(make_req(KindPresent, 32'h7, 48'd1000, '0));
      pending_reqs.push_back(make_req(KindPresent, 32'h7, 48'd800, '0));
      pending_reqs.push_back(make_req(KindSubmit, '0, '1, '0));
      pending_reqs.push_back(make_req(KindPresent, '0, '1, '0));
      pending_reqs.push_back(make_req(KindReserved, '1, '1, '1));
      drain();
      write_reg(CsrActive, 10'h3FF);
      write_reg(CsrNone, 10'h0);
      foreach (rates[r]) begin
         write_reg(CsrRate, rates[r]);
         for (int m = 0; m < 8; m++) begin
            write_reg(CsrMode, CsrDataW'(m));
            pending_reqs.push_back(make_req(KindQuery, '0, '1, 48'd1));
            pending_reqs.push_back(make_req(KindQuery, '0, 48'd100, '1));
            pending_reqs.push_back(make_req(KindQuery, '0, rand_time(), '0));
            random_phase(m == 4 ? 14 : 4);
            if (r == 2 && m == 3) begin
               wait (pending_reqs.size() == 0);
               hold_req = 1;
               wait (expected_rsps.size() == 0);
               hold_req = 0;
            end
            if (r == 1 && m == 0) idle_calm = 400;
            drain();
         end
      end
      write_reg(CsrActive, 10'h0);
      random_phase(100);
      drain();
      write_reg(CsrActive, 10'h1);
      write_reg(CsrMode, CsrDataW'(ModeVsync));
      write_reg(CsrRate, 10'd240);
      random_phase(1040);
      drain();

      if (errors == 0) $display("PASS frame_timing_deadline_tracker");
      else $display("FAIL frame_timing_deadline_tracker");
      $finish;
   end
endmodule
